// File: rtl/bcp_pkg.sv
// ----------------------------------------------------------------------------
// Box/cylinder push-out package
// Shared types, face codes and the halve-and-saturate helper.
// ----------------------------------------------------------------------------
`default_nettype none

package bcp_pkg;

   localparam int unsigned IN_BYTES  = 44;
   localparam int unsigned OUT_BYTES = 12;
   localparam int unsigned ROOT_W    = 32;

   localparam logic [1:0] FACE_LEFT  = 2'd0;
   localparam logic [1:0] FACE_RIGHT = 2'd1;
   localparam logic [1:0] FACE_FRONT = 2'd2;
   localparam logic [1:0] FACE_BACK  = 2'd3;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   // Context that rides along with the square root and divide pipeline.
   typedef struct packed {
      logic              hit;
      logic              outside;   // hit with the axis outside the rectangle
      logic              negx;
      logic              negz;
      logic [34:0]       clx;       // clamped point, doubled units, signed
      logic [34:0]       clz;
      logic [31:0]       fx;        // final X when no radial push applies
      logic [31:0]       fz;
      logic [31:0]       y;
   } ctx_type;

   // Halve a doubled value, rounding up or down, then clamp to 32 bits.
   function automatic logic [31:0] halve_sat(input logic [36:0] v, input logic up);
      logic [37:0] t;
      logic [36:0] h;
      t = {v[36], v} + {37'b0, up};
      h = t[37:1];
      if (h[36:31] == {6{h[31]}}) begin
         return h[31:0];
      end else if (h[36]) begin
         return SAT_MIN;
      end else begin
         return SAT_MAX;
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/bcp_root_div.sv
// ----------------------------------------------------------------------------
// Box/cylinder push-out root and divide pipeline
// Bit-per-stage integer square root of the squared distance, followed by two
// bit-per-stage dividers that scale the offset by radius over distance.
// ----------------------------------------------------------------------------
`default_nettype none

module bcp_root_div (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            vld_i,
   input  wire bcp_pkg::ctx_type ctx_i,
   input  wire logic [63:0]     sum_i,
   input  wire logic [63:0]     pax_i,
   input  wire logic [63:0]     paz_i,
   output logic                 vld_o,
   output bcp_pkg::ctx_type     ctx_o,
   output logic [31:0]          sx_o,
   output logic [31:0]          sz_o
);
   import bcp_pkg::*;

   // Square root stages.
   logic             sq_vld_ff  [ROOT_W];
   ctx_type          sq_ctx_ff  [ROOT_W];
   logic [63:0]      sq_s_ff    [ROOT_W];
   logic [33:0]      sq_rem_ff  [ROOT_W];
   logic [31:0]      sq_root_ff [ROOT_W];
   logic [63:0]      sq_px_ff   [ROOT_W];
   logic [63:0]      sq_pz_ff   [ROOT_W];
   logic [63:0]      sq_s_in    [ROOT_W];
   logic [33:0]      sq_rem_in  [ROOT_W];
   logic [31:0]      sq_root_in [ROOT_W];

   // Divide stages.
   logic             dv_vld_ff  [ROOT_W];
   ctx_type          dv_ctx_ff  [ROOT_W];
   logic [31:0]      dv_len_ff  [ROOT_W];
   logic [31:0]      dv_xr_ff   [ROOT_W];
   logic [31:0]      dv_xd_ff   [ROOT_W];
   logic [31:0]      dv_zr_ff   [ROOT_W];
   logic [31:0]      dv_zd_ff   [ROOT_W];
   logic [31:0]      dv_xr_in   [ROOT_W];
   logic [31:0]      dv_xd_in   [ROOT_W];
   logic [31:0]      dv_zr_in   [ROOT_W];
   logic [31:0]      dv_zd_in   [ROOT_W];

   logic [31:0]      len;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
      logic [63:0] s_cur;
      logic [33:0] rem_cur;
      logic [31:0] root_cur;
      logic [35:0] rem_t;
      logic [35:0] trial;
      logic [35:0] diff;
      logic        ge;
      if (k == 0) begin : g_first
         assign s_cur    = sum_i;
         assign rem_cur  = '0;
         assign root_cur = '0;
      end else begin : g_next
         assign s_cur    = sq_s_ff[k-1];
         assign rem_cur  = sq_rem_ff[k-1];
         assign root_cur = sq_root_ff[k-1];
      end
      assign rem_t         = {rem_cur, s_cur[63:62]};
      assign trial         = {2'b00, root_cur, 2'b01};
      assign diff          = rem_t - trial;
      assign ge            = rem_t >= trial;
      assign sq_s_in[k]    = {s_cur[61:0], 2'b00};
      assign sq_rem_in[k]  = ge ? diff[33:0] : rem_t[33:0];
      assign sq_root_in[k] = {root_cur[30:0], ge};
   end

   // A zero root only occurs on items that take no radial push.
   assign len = sq_root_ff[ROOT_W-1] | {31'b0, sq_root_ff[ROOT_W-1] == 32'b0};

   for (genvar k = 0; k < ROOT_W; k++) begin : g_dv
      logic [31:0] xr_cur, xd_cur, zr_cur, zd_cur, len_cur;
      logic [32:0] xt, zt, xdiff, zdiff;
      logic        xge, zge;
      if (k == 0) begin : g_first
         assign xr_cur  = sq_px_ff[ROOT_W-1][63:32];
         assign xd_cur  = sq_px_ff[ROOT_W-1][31:0];
         assign zr_cur  = sq_pz_ff[ROOT_W-1][63:32];
         assign zd_cur  = sq_pz_ff[ROOT_W-1][31:0];
         assign len_cur = len;
      end else begin : g_next
         assign xr_cur  = dv_xr_ff[k-1];
         assign xd_cur  = dv_xd_ff[k-1];
         assign zr_cur  = dv_zr_ff[k-1];
         assign zd_cur  = dv_zd_ff[k-1];
         assign len_cur = dv_len_ff[k-1];
      end
      assign xt          = {xr_cur, xd_cur[31]};
      assign zt          = {zr_cur, zd_cur[31]};
      assign xdiff       = xt - {1'b0, len_cur};
      assign zdiff       = zt - {1'b0, len_cur};
      assign xge         = xt >= {1'b0, len_cur};
      assign zge         = zt >= {1'b0, len_cur};
      assign dv_xr_in[k] = xge ? xdiff[31:0] : xt[31:0];
      assign dv_zr_in[k] = zge ? zdiff[31:0] : zt[31:0];
      assign dv_xd_in[k] = {xd_cur[30:0], xge};
      assign dv_zd_in[k] = {zd_cur[30:0], zge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROOT_W; k++) begin
            sq_vld_ff[k] <= 1'b0;
            dv_vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < ROOT_W; k++) begin
            sq_vld_ff[k] <= (k == 0) ? vld_i : sq_vld_ff[(k == 0) ? 0 : k-1];
            dv_vld_ff[k] <= (k == 0) ? sq_vld_ff[ROOT_W-1] : dv_vld_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ROOT_W; k++) begin
            sq_s_ff[k]    <= sq_s_in[k];
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
            dv_xr_ff[k]   <= dv_xr_in[k];
            dv_xd_ff[k]   <= dv_xd_in[k];
            dv_zr_ff[k]   <= dv_zr_in[k];
            dv_zd_ff[k]   <= dv_zd_in[k];
            if (k == 0) begin
               sq_ctx_ff[k] <= ctx_i;
               sq_px_ff[k]  <= pax_i;
               sq_pz_ff[k]  <= paz_i;
               dv_ctx_ff[k] <= sq_ctx_ff[ROOT_W-1];
               dv_len_ff[k] <= len;
            end else begin
               sq_ctx_ff[k] <= sq_ctx_ff[k-1];
               sq_px_ff[k]  <= sq_px_ff[k-1];
               sq_pz_ff[k]  <= sq_pz_ff[k-1];
               dv_ctx_ff[k] <= dv_ctx_ff[k-1];
               dv_len_ff[k] <= dv_len_ff[k-1];
            end
         end
      end
   end

   assign vld_o = dv_vld_ff[ROOT_W-1];
   assign ctx_o = dv_ctx_ff[ROOT_W-1];
   assign sx_o  = dv_xd_ff[ROOT_W-1];
   assign sz_o  = dv_zd_ff[ROOT_W-1];

`ifndef ASSERT_OFF
   // A radial push needs a nonzero distance from the root stages.
   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[ROOT_W-1] && sq_ctx_ff[ROOT_W-1].outside |-> sq_root_ff[ROOT_W-1] != 32'b0)
      else $error("root is zero for a radial push");

   // The quotient fits in 32 bits only if the high dividend half is below the root.
   a_quot_fits: assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[ROOT_W-1] && sq_ctx_ff[ROOT_W-1].outside
         |-> sq_px_ff[ROOT_W-1][63:32] < len && sq_pz_ff[ROOT_W-1][63:32] < len)
      else $error("divider quotient overflow");

   // A stalled pipeline holds its last stage.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_o))
      else $error("last stage changed during stall");
`endif

endmodule

`default_nettype wire

// File: rtl/box_cylinder_pushout.sv
// ----------------------------------------------------------------------------
// Box versus upright cylinder collision with XZ push-out
// Tests a box against a cylinder and pushes the cylinder out of the box.
// ----------------------------------------------------------------------------
// One transaction carries a box and a cylinder in signed Q16.16 and returns one
// result: the hit flag and the cylinder position, pushed out in X and Z on a
// hit and echoed on a miss. The block takes one transaction every clock cycle
// while not stalled; each one passes through three setup stages, 32 square
// root stages, 32 divide stages and the output register. The whole pipeline
// advances whenever the output register is empty or its result is taken.
`default_nettype none

module box_cylinder_pushout (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // box_x, box_y, box_z, box_width, box_height, box_depth,
   // cyl_x, cyl_y, cyl_z, cyl_radius, cyl_height, zero fill
   input  wire logic [bcp_pkg::IN_BYTES*8-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // new_x, new_y, new_z
   output logic [bcp_pkg::OUT_BYTES*8-1:0] rsp_tdata,
   // hit
   output logic [0:0]        rsp_tuser
);
   import bcp_pkg::*;

   logic en;

   // Input decode.
   logic [31:0] box_x, box_y, box_z, cyl_x, cyl_y, cyl_z;
   logic [30:0] box_width, box_height, box_depth, cyl_radius, cyl_height;
   assign box_x      = req_tdata[31:0];
   assign box_y      = req_tdata[63:32];
   assign box_z      = req_tdata[95:64];
   assign box_width  = req_tdata[126:96];
   assign box_height = req_tdata[157:127];
   assign box_depth  = req_tdata[188:158];
   assign cyl_x      = req_tdata[220:189];
   assign cyl_y      = req_tdata[252:221];
   assign cyl_z      = req_tdata[284:253];
   assign cyl_radius = req_tdata[315:285];
   assign cyl_height = req_tdata[346:316];

   // Stage A: doubled coordinates, clamp, vertical and coarse range test.
   logic signed [35:0] cx2, cz2, minx, maxx, minz, maxz, clx, clz, dx, dz;
   logic signed [35:0] ybot, ytop, bbot, btop;
   logic [35:0]        adx, adz;
   logic [31:0]        ar;
   logic               a_miss_in;

   assign cx2  = {{3{cyl_x[31]}}, cyl_x, 1'b0};
   assign cz2  = {{3{cyl_z[31]}}, cyl_z, 1'b0};
   assign minx = {{3{box_x[31]}}, box_x, 1'b0} - {5'b0, box_width};
   assign maxx = {{3{box_x[31]}}, box_x, 1'b0} + {5'b0, box_width};
   assign minz = {{3{box_z[31]}}, box_z, 1'b0} - {5'b0, box_depth};
   assign maxz = {{3{box_z[31]}}, box_z, 1'b0} + {5'b0, box_depth};
   assign clx  = (cx2 < minx) ? minx : ((cx2 > maxx) ? maxx : cx2);
   assign clz  = (cz2 < minz) ? minz : ((cz2 > maxz) ? maxz : cz2);
   assign dx   = cx2 - clx;
   assign dz   = cz2 - clz;
   assign adx  = dx[35] ? 36'(-dx) : 36'(dx);
   assign adz  = dz[35] ? 36'(-dz) : 36'(dz);
   assign ar   = {cyl_radius, 1'b0};
   assign ybot = {{3{cyl_y[31]}}, cyl_y, 1'b0};
   assign ytop = ybot + {4'b0, cyl_height, 1'b0};
   assign bbot = {{3{box_y[31]}}, box_y, 1'b0} - {5'b0, box_height};
   assign btop = {{3{box_y[31]}}, box_y, 1'b0} + {5'b0, box_height};
   assign a_miss_in = (ybot > btop) || (ytop < bbot)
                      || (adx > {4'b0, ar}) || (adz > {4'b0, ar});

   logic        a_vld_ff, a_miss_ff, a_negx_ff, a_negz_ff;
   logic [31:0] a_adx_ff, a_adz_ff, a_ar_ff, a_cx_ff, a_cy_ff, a_cz_ff;
   logic signed [35:0] a_cx2_ff, a_cz2_ff, a_minx_ff, a_maxx_ff, a_minz_ff, a_maxz_ff;
   logic signed [35:0] a_clx_ff, a_clz_ff;

   // Stage B: products and nearest face.
   logic signed [35:0] dl, dr, df, db, best1, best2;
   logic [1:0]         face;
   logic [31:0]        b_facex_in, b_facez_in;
   logic [36:0]        ar37;

   assign dl = a_cx2_ff - a_minx_ff;
   assign dr = a_maxx_ff - a_cx2_ff;
   assign df = a_cz2_ff - a_minz_ff;
   assign db = a_maxz_ff - a_cz2_ff;
   assign ar37 = {5'b0, a_ar_ff};

   always_comb begin
      face  = FACE_LEFT;
      best1 = dl;
      if (dr < best1) begin
         face  = FACE_RIGHT;
         best1 = dr;
      end
      best2 = best1;
      if (df < best2) begin
         face  = FACE_FRONT;
         best2 = df;
      end
      if (db < best2) begin
         face = FACE_BACK;
      end
      b_facex_in = a_cx_ff;
      b_facez_in = a_cz_ff;
      unique case (face)
         FACE_LEFT:  b_facex_in = halve_sat({a_minx_ff[35], a_minx_ff} - ar37, 1'b0);
         FACE_RIGHT: b_facex_in = halve_sat({a_maxx_ff[35], a_maxx_ff} + ar37, 1'b1);
         FACE_FRONT: b_facez_in = halve_sat({a_minz_ff[35], a_minz_ff} - ar37, 1'b0);
         FACE_BACK:  b_facez_in = halve_sat({a_maxz_ff[35], a_maxz_ff} + ar37, 1'b1);
         default:    b_facex_in = a_cx_ff;
      endcase
   end

   logic        b_vld_ff, b_miss_ff, b_negx_ff, b_negz_ff;
   logic [63:0] b_a_ff, b_b_ff, b_rsq_ff, b_pax_ff, b_paz_ff;
   logic [31:0] b_facex_ff, b_facez_ff, b_cx_ff, b_cy_ff, b_cz_ff;
   logic [34:0] b_clx_ff, b_clz_ff;

   // Stage C: hit decision and the squared distance.
   logic [64:0] sum;
   logic        c_hit_in, c_inside;
   ctx_type     c_ctx_in;

   assign sum      = {1'b0, b_a_ff} + {1'b0, b_b_ff};
   assign c_hit_in = !b_miss_ff && (sum <= {1'b0, b_rsq_ff});
   assign c_inside = (sum == 65'b0);

   always_comb begin
      c_ctx_in.hit     = c_hit_in;
      c_ctx_in.outside = c_hit_in && !c_inside;
      c_ctx_in.negx    = b_negx_ff;
      c_ctx_in.negz    = b_negz_ff;
      c_ctx_in.clx     = b_clx_ff;
      c_ctx_in.clz     = b_clz_ff;
      c_ctx_in.fx      = (c_hit_in && c_inside) ? b_facex_ff : b_cx_ff;
      c_ctx_in.fz      = (c_hit_in && c_inside) ? b_facez_ff : b_cz_ff;
      c_ctx_in.y       = b_cy_ff;
   end

   logic        c_vld_ff;
   ctx_type     c_ctx_ff;
   logic [63:0] c_sum_ff, c_pax_ff, c_paz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_tvalid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_miss_ff  <= a_miss_in;
         a_negx_ff  <= dx[35];
         a_negz_ff  <= dz[35];
         a_adx_ff   <= adx[31:0];
         a_adz_ff   <= adz[31:0];
         a_ar_ff    <= ar;
         a_cx_ff    <= cyl_x;
         a_cy_ff    <= cyl_y;
         a_cz_ff    <= cyl_z;
         a_cx2_ff   <= cx2;
         a_cz2_ff   <= cz2;
         a_minx_ff  <= minx;
         a_maxx_ff  <= maxx;
         a_minz_ff  <= minz;
         a_maxz_ff  <= maxz;
         a_clx_ff   <= clx;
         a_clz_ff   <= clz;

         b_miss_ff  <= a_miss_ff;
         b_negx_ff  <= a_negx_ff;
         b_negz_ff  <= a_negz_ff;
         b_a_ff     <= a_adx_ff * a_adx_ff;
         b_b_ff     <= a_adz_ff * a_adz_ff;
         b_rsq_ff   <= a_ar_ff * a_ar_ff;
         b_pax_ff   <= a_adx_ff * a_ar_ff;
         b_paz_ff   <= a_adz_ff * a_ar_ff;
         b_facex_ff <= b_facex_in;
         b_facez_ff <= b_facez_in;
         b_cx_ff    <= a_cx_ff;
         b_cy_ff    <= a_cy_ff;
         b_cz_ff    <= a_cz_ff;
         b_clx_ff   <= a_clx_ff[34:0];
         b_clz_ff   <= a_clz_ff[34:0];

         c_ctx_ff   <= c_ctx_in;
         c_sum_ff   <= sum[63:0];
         c_pax_ff   <= b_pax_ff;
         c_paz_ff   <= b_paz_ff;
      end
   end

   logic        rd_vld;
   ctx_type     rd_ctx;
   logic [31:0] rd_sx, rd_sz;

   bcp_root_div u_root_div (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .vld_i (c_vld_ff),
      .ctx_i (c_ctx_ff),
      .sum_i (c_sum_ff),
      .pax_i (c_pax_ff),
      .paz_i (c_paz_ff),
      .vld_o (rd_vld),
      .ctx_o (rd_ctx),
      .sx_o  (rd_sx),
      .sz_o  (rd_sz)
   );

   // Final stage: clamped point plus the scaled offset, halved away from the box.
   logic [36:0] clx37, clz37, nx, nz;
   logic [31:0] px, pz;

   assign clx37 = {{2{rd_ctx.clx[34]}}, rd_ctx.clx};
   assign clz37 = {{2{rd_ctx.clz[34]}}, rd_ctx.clz};
   assign nx    = rd_ctx.negx ? clx37 - {5'b0, rd_sx} : clx37 + {5'b0, rd_sx};
   assign nz    = rd_ctx.negz ? clz37 - {5'b0, rd_sz} : clz37 + {5'b0, rd_sz};
   assign px    = rd_ctx.outside ? halve_sat(nx, !rd_ctx.negx) : rd_ctx.fx;
   assign pz    = rd_ctx.outside ? halve_sat(nz, !rd_ctx.negz) : rd_ctx.fz;

   logic        out_vld_ff;
   logic [95:0] out_data_ff;
   logic        out_hit_ff;

   assign en = !out_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= rd_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= {pz, rd_ctx.y, px};
         out_hit_ff  <= rd_ctx.hit;
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_hit_ff;

endmodule

`default_nettype wire

// File: sim/box_cylinder_pushout_tb.sv
// ----------------------------------------------------------------------------
// Box/cylinder push-out testbench
// Streams box and cylinder pairs through the block under random idling and
// compares every result with an in-bench prediction of the collision push.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_cylinder_pushout_tb;

   localparam int PIPE_CYCLES  = 68;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1300;

   typedef struct packed {
      logic signed [31:0] box_x;
      logic signed [31:0] box_y;
      logic signed [31:0] box_z;
      logic [30:0]        box_width;
      logic [30:0]        box_height;
      logic [30:0]        box_depth;
      logic signed [31:0] cyl_x;
      logic signed [31:0] cyl_y;
      logic signed [31:0] cyl_z;
      logic [30:0]        cyl_radius;
      logic [30:0]        cyl_height;
   } pair_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] new_x;
      logic [31:0] new_y;
      logic [31:0] new_z;
   } push_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [bcp_pkg::IN_BYTES*8-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [bcp_pkg::OUT_BYTES*8-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   pair_type pending_pairs[$];
   push_type expected_pushes[$];
   int    mismatches = 0;
   int    hits_seen = 0;
   int    results_seen = 0;
   int    cycle_count = 0;
   bit    stim_done = 1'b0;
   int    send_gap = 0;
   int    recv_gap = 0;
   int    long_hold = 0;
   bit    hold_done = 1'b0;

   box_cylinder_pushout dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [351:0] pack_pair(pair_type p);
      return {5'b0, p.cyl_height, p.cyl_radius, p.cyl_z, p.cyl_y, p.cyl_x,
              p.box_depth, p.box_height, p.box_width, p.box_z, p.box_y, p.box_x};
   endfunction

   function automatic longint halve_doubled(longint v, bit up);
      if (up) return v >= 0 ? (v + 1) / 2 : -((-v) / 2);
      return v >= 0 ? v / 2 : -((-v + 1) / 2);
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic longint unsigned root_floor(longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic push_type predict_push(pair_type p);
      longint bx, by, bz, bw, bh, bd, cx, cy, cz, rr, ch;
      longint cx2, cz2, r2, minx, maxx, minz, maxz, px, pz, clx, clz, dx, dz;
      longint dl, dr, df, db, best, sx, sz, nx, nz;
      longint unsigned adx, adz, ar, rsq, a, b, len;
      logic [1:0] face;
      bit hit;
      push_type res;
      bx = p.box_x; by = p.box_y; bz = p.box_z;
      bw = p.box_width; bh = p.box_height; bd = p.box_depth;
      cx = p.cyl_x; cy = p.cyl_y; cz = p.cyl_z;
      rr = p.cyl_radius; ch = p.cyl_height;
      cx2 = 2 * cx; cz2 = 2 * cz; r2 = 2 * rr;
      minx = 2 * bx - bw; maxx = 2 * bx + bw;
      minz = 2 * bz - bd; maxz = 2 * bz + bd;
      px = cx; pz = cz;
      hit = 1'b0;
      if (!(2 * cy > 2 * by + bh || 2 * (cy + ch) < 2 * by - bh)) begin
         clx = cx2 < minx ? minx : (cx2 > maxx ? maxx : cx2);
         clz = cz2 < minz ? minz : (cz2 > maxz ? maxz : cz2);
         dx = cx2 - clx; dz = cz2 - clz;
         adx = dx < 0 ? -dx : dx;
         adz = dz < 0 ? -dz : dz;
         ar = r2;
         rsq = ar * ar; a = adx * adx; b = adz * adz;
         // Sums fit in 64 bits only once each offset is within the radius.
         if (adx <= ar && adz <= ar && a <= rsq && b <= rsq - a) begin
            hit = 1'b1;
            if (a + b == 0) begin
               dl = cx2 - minx; dr = maxx - cx2; df = cz2 - minz; db = maxz - cz2;
               best = dl; face = bcp_pkg::FACE_LEFT;
               if (dr < best) begin best = dr; face = bcp_pkg::FACE_RIGHT; end
               if (df < best) begin best = df; face = bcp_pkg::FACE_FRONT; end
               if (db < best) begin best = db; face = bcp_pkg::FACE_BACK; end
               case (face)
                  bcp_pkg::FACE_LEFT:  px = halve_doubled(minx - r2, 1'b0);
                  bcp_pkg::FACE_RIGHT: px = halve_doubled(maxx + r2, 1'b1);
                  bcp_pkg::FACE_FRONT: pz = halve_doubled(minz - r2, 1'b0);
                  default:             pz = halve_doubled(maxz + r2, 1'b1);
               endcase
            end else begin
               len = root_floor(a + b);
               if (len == 0) len = 1;
               sx = (adx * ar) / len;
               sz = (adz * ar) / len;
               nx = dx < 0 ? clx - sx : clx + sx;
               nz = dz < 0 ? clz - sz : clz + sz;
               px = halve_doubled(nx, dx >= 0);
               pz = halve_doubled(nz, dz >= 0);
            end
         end
      end
      res.hit = hit;
      res.new_x = clamp32(px);
      res.new_y = p.cyl_y;
      res.new_z = clamp32(pz);
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s got %h expected %h",
               results_seen, what, got, want);
      mismatches++;
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] rand_coord(int span);
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, span) - span / 2;
         default: return ($urandom_range(0, 2 * span) - span) <<< 4;
      endcase
   endfunction

   function automatic logic [30:0] rand_size(int span);
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 31'd0;
         default: return $urandom_range(0, span) << 4;
      endcase
   endfunction

   function automatic pair_type make_pair(logic [31:0] bx, logic [31:0] bz, logic [30:0] w,
                                          logic [30:0] d, logic [31:0] cx, logic [31:0] cz,
                                          logic [30:0] r);
      pair_type p;
      p.box_x = bx; p.box_y = 0; p.box_z = bz;
      p.box_width = w; p.box_height = 31'h20000; p.box_depth = d;
      p.cyl_x = cx; p.cyl_y = -32'sh8000; p.cyl_z = cz;
      p.cyl_radius = r; p.cyl_height = 31'h10000;
      return p;
   endfunction

   initial begin
      pair_type p;
      int span;
      // Vertical misses above and below, and a touching top and a touching bottom.
      p = make_pair(0, 0, 31'h20000, 31'h20000, 0, 0, 31'h8000);
      p.cyl_y = 32'sh20000; pending_pairs.push_back(p);
      p.cyl_y = 32'sh10000; pending_pairs.push_back(p);
      p.cyl_y = -32'sh30000; pending_pairs.push_back(p);
      p.cyl_y = -32'sh20000; pending_pairs.push_back(p);
      // Nearest face for each side, and ties resolved toward the earlier face.
      pending_pairs.push_back(make_pair(0, 0, 31'h40000, 31'h80000, -32'sh18000, 0, 31'h8000));
      pending_pairs.push_back(make_pair(0, 0, 31'h40000, 31'h80000, 32'sh18000, 0, 31'h8000));
      pending_pairs.push_back(make_pair(0, 0, 31'h80000, 31'h40000, 0, -32'sh18000, 31'h8000));
      pending_pairs.push_back(make_pair(0, 0, 31'h80000, 31'h40000, 0, 32'sh18000, 31'h8000));
      pending_pairs.push_back(make_pair(0, 0, 31'h40000, 31'h40000, 0, 0, 31'h8001));
      pending_pairs.push_back(make_pair(0, 0, 31'h3, 31'h3, 0, 0, 31'h1));
      // Outside the rectangle: radial push, touching, just missing, zero radius.
      pending_pairs.push_back(make_pair(0, 0, 31'h20000, 31'h20000, 32'sh18000, 32'sh18000,
                                        31'h10000));
      pending_pairs.push_back(make_pair(0, 0, 31'h20000, 31'h20000, 32'sh20000, 0, 31'h10000));
      pending_pairs.push_back(make_pair(0, 0, 31'h20000, 31'h20000, 32'sh20001, 0, 31'h10000));
      pending_pairs.push_back(make_pair(0, 0, 31'h20000, 31'h20000, 32'sh10000, 0, 31'h0));
      pending_pairs.push_back(make_pair(0, 0, 31'h20000, 31'h20000, 32'sh10001, 0, 31'h0));
      pending_pairs.push_back(make_pair(0, 0, 31'h0, 31'h0, 32'sh7, -32'sh5, 31'h9));
      // Saturation at both ends of the range, and all-zero and all-one fields.
      pending_pairs.push_back(make_pair(32'sh7FFF0000, 0, 31'h20000, 31'h20000,
                                        32'sh7FFF8000, 0, 31'h7FFFFFFF));
      pending_pairs.push_back(make_pair(32'sh80010000, 0, 31'h20000, 31'h20000,
                                        32'sh80008000, 0, 31'h7FFFFFFF));
      pending_pairs.push_back(make_pair(32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF,
                                        31'h7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                        31'h7FFFFFFF));
      pending_pairs.push_back('0);
      pending_pairs.push_back('1);
      p = '1; p.box_x = 32'sh80000000; p.cyl_z = 32'sh80000000;
      pending_pairs.push_back(p);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         span = ($urandom_range(0, 3) == 0) ? 32'h7FFFFFFF : 32'h80000;
         p.box_x = rand_coord(span); p.box_y = rand_coord(span); p.box_z = rand_coord(span);
         p.box_width = rand_size(span); p.box_height = rand_size(span);
         p.box_depth = rand_size(span);
         p.cyl_radius = rand_size(span / 2); p.cyl_height = rand_size(span);
         if ($urandom_range(0, 9) < 7) begin
            // Place the cylinder near the box so most pairs reach the XZ tests.
            p.cyl_x = p.box_x + $signed($urandom_range(0, 2 * span / 16) - span / 16);
            p.cyl_z = p.box_z + $signed($urandom_range(0, 2 * span / 16) - span / 16);
            p.cyl_y = p.box_y - $signed({1'b0, p.cyl_height} >> 1);
         end else begin
            p.cyl_x = rand_coord(span); p.cyl_y = rand_coord(span); p.cyl_z = rand_coord(span);
         end
         pending_pairs.push_back(p);
      end
      stim_done = 1'b1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 9) reset <= 1'b0;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("box_cylinder_pushout test failed");
         $finish;
      end
   end

   // Driver: a new transaction is loaded only after the current one is taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_pushes.push_back(predict_push(pending_pairs.pop_front()));
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
               req_tdata <= pack_pair(pending_pairs[0]);
               req_tvalid <= 1'b1;
               send_gap <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off once, early in the random part.
   always @(posedge clock) begin
      if (!reset && !hold_done && results_seen >= 100) begin
         long_hold <= long_hold + 1;
         if (long_hold >= 300) hold_done <= 1'b1;
      end
   end

   // Monitor.
   always @(posedge clock) begin
      push_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[0], rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64]};
            results_seen++;
            if (got.hit) hits_seen++;
            if (expected_pushes.size() == 0) begin
               $display("unexpected result %0d", results_seen);
               mismatches++;
            end else begin
               want = expected_pushes.pop_front();
               if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
               if (got.new_x !== want.new_x) report_mismatch("new_x", got.new_x, want.new_x);
               if (got.new_y !== want.new_y) report_mismatch("new_y", got.new_y, want.new_y);
               if (got.new_z !== want.new_z) report_mismatch("new_z", got.new_z, want.new_z);
            end
         end
         if (results_seen >= 100 && !hold_done) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
         end
      end
   end

   initial begin
      wait (stim_done);
      wait (!reset && pending_pairs.size() == 0 && !req_tvalid);
      wait (expected_pushes.size() == 0);
      repeat (2 * PIPE_CYCLES) @(posedge clock);
      $display("%0d pairs checked, %0d of them hits, including face, radial,",
               results_seen, hits_seen);
      $display("vertical miss and saturation cases under random stalls.");
      if (mismatches == 0) begin
         $display("box_cylinder_pushout test passed");
      end else begin
         $display("box_cylinder_pushout test failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/bcp_pkg.sv
rtl/bcp_root_div.sv
rtl/box_cylinder_pushout.sv
sim/box_cylinder_pushout_tb.sv
